// ===== hdl/sha384_pkg.sv =====
// SHA-384 shared types, constants and round functions
package sha384_pkg;

   localparam int unsigned ROUNDS      = 80;
   localparam int unsigned DIGEST_WORDS = 6;

   localparam logic [63:0] ROUND_K [0:79] = '{
      64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
      64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
      64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
      64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
      64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
      64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
      64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
      64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
      64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
      64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
      64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
      64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
      64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
      64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
      64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
      64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
      64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
      64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
      64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
      64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
   };

   localparam logic [63:0] INIT_HASH [0:7] = '{
      64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507,
      64'h9159015A3070DD17, 64'h152FECD8F70E5939,
      64'h67332667FFC00B31, 64'h8EB44A8768581511,
      64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
   };

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [3:0] LEN_HI_POS = 4'd14;

   // word source for the buffer write
   typedef enum logic [1:0] {
      SRC_DATA  = 2'd0,
      SRC_ZERO  = 2'd1,
      SRC_LEN_H = 2'd2,
      SRC_LEN_L = 2'd3
   } word_src_type;

   typedef struct packed {
      logic         push;       // write a word into the buffer
      word_src_type src;
      logic         add_len;    // add byte count to bit length
      logic         start;      // begin compression
      logic         clear;      // return chain, fill, length to reset
   } dp_cmd_type;

   typedef struct packed {
      logic       busy;         // compression running
      logic [3:0] fill;
   } dp_status_type;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] sig0(input logic [63:0] y);
      sig0 = rotr(y, 1) ^ rotr(y, 8) ^ (y >> 7);
   endfunction

   function automatic logic [63:0] sig1(input logic [63:0] x);
      sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic logic [63:0] bsig0(input logic [63:0] a);
      bsig0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
   endfunction

   function automatic logic [63:0] bsig1(input logic [63:0] e);
      bsig1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
   endfunction

endpackage

// ===== hdl/sha384_if.sv =====
// Valid/ready channel interfaces for the SHA-384 hasher
interface sha384_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  valid_bytes;
   logic        final_word;
   modport source (output valid, data_word, valid_bytes, final_word, input ready);
   modport sink   (input valid, data_word, valid_bytes, final_word, output ready);
endinterface

interface sha384_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  digest_index;
   logic        digest_last;
   modport source (output valid, digest_word, digest_index, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// ===== hdl/sha384_datapath.sv =====
// SHA-384 datapath: block buffer, message schedule, round unit, chain state, length
module sha384_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  sha384_pkg::dp_cmd_type      cmd,
   input  logic [63:0]                 data_in,
   input  logic [3:0]                  nbytes,
   input  logic [2:0]                  out_sel,
   output logic [63:0]                 out_word,
   output sha384_pkg::dp_status_type   status
);

   logic [63:0] buf_ff [0:15];
   logic [63:0] w_ff   [0:15];
   logic [63:0] v_ff   [0:7];
   logic [63:0] h_ff   [0:7];
   logic [3:0]  fill_ff;
   logic [63:0] len_hi_ff, len_lo_ff;
   logic [6:0]  round_ff;
   logic        busy_ff;
   logic        fold_ff;

   logic [63:0] wr_word;
   logic [64:0] len_sum;
   logic [63:0] t1, t2, w_new;

   always_comb begin
      case (cmd.src)
         sha384_pkg::SRC_DATA:  wr_word = data_in;
         sha384_pkg::SRC_ZERO:  wr_word = '0;
         sha384_pkg::SRC_LEN_H: wr_word = len_hi_ff;
         sha384_pkg::SRC_LEN_L: wr_word = len_lo_ff;
         default:               wr_word = '0;
      endcase
   end

   assign len_sum = {1'b0, len_lo_ff} + {58'd0, nbytes, 3'd0};

   assign t1 = v_ff[7] + sha384_pkg::bsig1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + sha384_pkg::ROUND_K[round_ff] + w_ff[0];
   assign t2 = sha384_pkg::bsig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_new = sha384_pkg::sig1(w_ff[14]) + w_ff[9] + sha384_pkg::sig0(w_ff[1]) + w_ff[0];

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         buf_ff[fill_ff] <= wr_word;
      end
      if (cmd.start) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= buf_ff[i];
         end
         // take the closing word straight from the write port
         w_ff[15] <= wr_word;
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha384_pkg::INIT_HASH[i];
         end
         fill_ff   <= '0;
         len_hi_ff <= '0;
         len_lo_ff <= '0;
         round_ff  <= '0;
         busy_ff   <= 1'b0;
         fold_ff   <= 1'b0;
      end else begin
         if (cmd.push) begin
            fill_ff <= fill_ff + 4'd1;
         end
         if (cmd.add_len) begin
            len_lo_ff <= len_sum[63:0];
            len_hi_ff <= len_hi_ff + {63'd0, len_sum[64]};
         end
         fold_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
         end else if (busy_ff) begin
            if (round_ff == 7'(sha384_pkg::ROUNDS - 1)) begin
               busy_ff <= 1'b0;
               fold_ff <= 1'b1;
            end
            round_ff <= round_ff + 7'd1;
         end
         if (fold_ff) begin
            for (int i = 0; i < 8; i++) begin
               h_ff[i] <= h_ff[i] + v_ff[i];
            end
         end
      end
   end

   assign out_word    = h_ff[out_sel];
   assign status.busy = busy_ff | fold_ff;
   assign status.fill = fill_ff;

`ifndef SYNTHESIS
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> round_ff < 7'(sha384_pkg::ROUNDS)) else $error("round out of range");
   a_no_push_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.push) else $error("buffer written during compression");
   a_fold_after: assert property (@(posedge clock) disable iff (reset)
      fold_ff |-> $past(busy_ff)) else $error("fold without compression");
   a_start_full: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> cmd.push && fill_ff == 4'd15) else $error("start on a partial block");
`endif

endmodule

// ===== hdl/sha384_controller.sv =====
// SHA-384 controller: word intake, padding sequence and digest output
module sha384_controller (
   input  logic                        clock,
   input  logic                        reset,
   sha384_req_if.sink                  req,
   sha384_rsp_if.source                rsp,
   input  sha384_pkg::dp_status_type   status,
   input  logic [63:0]                 out_word,
   output sha384_pkg::dp_cmd_type      cmd,
   output logic [63:0]                 data_in,
   output logic [3:0]                  nbytes,
   output logic [2:0]                  out_sel
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_HASH  = 6'b000010,
      ST_PAD80 = 6'b000100,
      ST_ZERO  = 6'b001000,
      ST_LEN   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic        fin_ff, fin_in;        // message ended: padding path
   logic        lenlo_ff, lenlo_in;    // high length word written
   logic        p80_ff, p80_in;        // pad byte word still owed after the compression
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] pad_word;
   logic [3:0]  nb_sat;
   logic [63:0] keep;
   logic        acc, block_full;

   assign nb_sat = (req.valid_bytes > 4'd8) ? 4'd8 : req.valid_bytes;
   assign keep   = (nb_sat == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {nb_sat, 3'd0});
   assign pad_word = (req.data_word & keep)
                   | ({sha384_pkg::PAD_BYTE, 56'd0} >> {nb_sat, 3'd0});

   assign req.ready  = (state_ff == ST_IDLE);
   assign acc        = req.valid && req.ready;
   assign block_full = (status.fill == 4'd15);

   assign rsp.valid        = (state_ff == ST_OUT);
   assign rsp.digest_word  = out_word;
   assign rsp.digest_index = idx_ff;
   assign rsp.digest_last  = (idx_ff == 3'(sha384_pkg::DIGEST_WORDS - 1));
   assign out_sel          = idx_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      lenlo_in = lenlo_ff;
      p80_in   = p80_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.src  = sha384_pkg::SRC_DATA;
      data_in  = req.data_word;
      nbytes   = req.final_word ? nb_sat : 4'd8;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.push    = 1'b1;
               cmd.add_len = 1'b1;
               if (!req.final_word) begin
                  if (block_full) begin
                     cmd.start = 1'b1;
                     state_in  = ST_HASH;
                  end
               end else begin
                  fin_in = 1'b1;
                  if (nb_sat != 4'd8) begin
                     data_in = pad_word;
                  end
                  if (nb_sat == 4'd8) begin
                     cmd.start = block_full;
                     p80_in    = block_full;
                     state_in  = block_full ? ST_HASH : ST_PAD80;
                  end else if (block_full) begin
                     cmd.start = 1'b1;
                     state_in  = ST_HASH;
                  end else begin
                     state_in = (status.fill + 4'd1 == sha384_pkg::LEN_HI_POS) ? ST_LEN
                                                                              : ST_ZERO;
                  end
               end
            end
         end
         ST_HASH: begin
            if (!status.busy) begin
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (lenlo_ff) begin
                  idx_in   = '0;
                  state_in = ST_OUT;
               end else if (p80_ff) begin
                  p80_in   = 1'b0;
                  state_in = ST_PAD80;
               end else begin
                  state_in = ST_ZERO;
               end
            end
         end
         ST_PAD80: begin
            cmd.push = 1'b1;
            data_in  = {sha384_pkg::PAD_BYTE, 56'd0};
            if (block_full) begin
               cmd.start = 1'b1;
               state_in  = ST_HASH;
            end else begin
               state_in = (status.fill + 4'd1 == sha384_pkg::LEN_HI_POS) ? ST_LEN : ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.fill == sha384_pkg::LEN_HI_POS) begin
               state_in = ST_LEN;
            end else begin
               cmd.push = 1'b1;
               cmd.src  = sha384_pkg::SRC_ZERO;
               if (block_full) begin
                  cmd.start = 1'b1;
                  state_in  = ST_HASH;
               end
            end
         end
         ST_LEN: begin
            cmd.push = 1'b1;
            if (!lenlo_ff) begin
               cmd.src  = sha384_pkg::SRC_LEN_H;
               lenlo_in = 1'b1;
            end else begin
               cmd.src   = sha384_pkg::SRC_LEN_L;
               cmd.start = 1'b1;
               state_in  = ST_HASH;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (rsp.digest_last) begin
                  cmd.clear = 1'b1;
                  fin_in    = 1'b0;
                  lenlo_in  = 1'b0;
                  p80_in    = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         lenlo_ff <= 1'b0;
         p80_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         lenlo_ff <= lenlo_in;
         p80_ff   <= p80_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_out_idx: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> idx_ff < 3'(sha384_pkg::DIGEST_WORDS)) else $error("digest index");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(idx_ff)) else $error("output dropped");
   a_len_fin: assert property (@(posedge clock) disable iff (reset)
      lenlo_ff |-> fin_ff) else $error("length written outside padding");
`endif

endmodule

// ===== hdl/sha384_stream_hasher_core.sv =====
// SHA-384 stream hasher top level
//  channel | dir | handshake               | payload
//  req     | in  | req_valid / req_ready   | data_word, valid_bytes, final_word
//  rsp     | out | rsp_valid / rsp_ready   | digest_word, digest_index, digest_last
// A word is taken while the core is idle; the 16th word of a block starts the compression,
// whose rounds run on the single round unit and end in a fold into the chain state.
// Padding writes each padding word in turn, with a hand-over step before the length words
// when zero words precede them, plus a second compression when needed.
// Six digest words follow, one per cycle while rsp_ready stays high.
// reset is synchronous; stalls on rsp hold the current digest word.
module sha384_stream_hasher_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [63:0]  req_data_word,
   input  logic [3:0]   req_valid_bytes,
   input  logic         req_final_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [63:0]  rsp_digest_word,
   output logic [2:0]   rsp_digest_index,
   output logic         rsp_digest_last
);

   sha384_req_if req ();
   sha384_rsp_if rsp ();

   sha384_pkg::dp_cmd_type    cmd;
   sha384_pkg::dp_status_type status;
   logic [63:0] data_in, out_word;
   logic [3:0]  nbytes;
   logic [2:0]  out_sel;

   assign req.valid       = req_valid;
   assign req_ready       = req.ready;
   assign req.data_word   = req_data_word;
   assign req.valid_bytes = req_valid_bytes;
   assign req.final_word  = req_final_word;

   assign rsp_valid        = rsp.valid;
   assign rsp.ready        = rsp_ready;
   assign rsp_digest_word  = rsp.digest_word;
   assign rsp_digest_index = rsp.digest_index;
   assign rsp_digest_last  = rsp.digest_last;

   sha384_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .status   (status),
      .out_word (out_word),
      .cmd      (cmd),
      .data_in  (data_in),
      .nbytes   (nbytes),
      .out_sel  (out_sel)
   );

   sha384_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .data_in  (data_in),
      .nbytes   (nbytes),
      .out_sel  (out_sel),
      .out_word (out_word),
      .status   (status)
   );

endmodule

// ===== test/sha384_tb_if.sv =====
// Testbench channel interfaces for the SHA-384 stream hasher
interface sha384_tb_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  valid_bytes;
   logic        final_word;
   modport source (output valid, data_word, valid_bytes, final_word, input ready);
   modport sink   (input valid, data_word, valid_bytes, final_word, output ready);
endinterface

interface sha384_tb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  digest_index;
   logic        digest_last;
   modport source (output valid, digest_word, digest_index, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// ===== test/sha384_stream_hasher_core_tb.sv =====
// Self-checking testbench for the SHA-384 stream hasher core
module sha384_stream_hasher_core_tb;

   typedef struct {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   sha384_tb_req_if req ();
   sha384_tb_rsp_if rsp ();

   sha384_stream_hasher_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req.valid),
      .req_ready        (req.ready),
      .req_data_word    (req.data_word),
      .req_valid_bytes  (req.valid_bytes),
      .req_final_word   (req.final_word),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_digest_word  (rsp.digest_word),
      .rsp_digest_index (rsp.digest_index),
      .rsp_digest_last  (rsp.digest_last)
   );

   localparam int HOLD_OFF_LEN = 600;

   logic [63:0]     hash_state [0:7];
   logic [63:0]     msg_block [0:15];
   int unsigned     msg_fill;
   logic [127:0]    msg_bits;
   digest_item_type digest_queue [$];
   int              errors = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   logic            hold_off_req;
   logic            hold_off_seen;
   int              hold_off_cycles;

   localparam logic [63:0] SHA_K [0:79] = '{
      64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
      64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
      64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
      64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
      64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
      64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
      64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
      64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
      64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
      64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
      64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
      64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
      64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
      64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
      64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
      64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
      64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
      64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
      64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
      64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
   };

   localparam logic [63:0] SHA384_IV [0:7] = '{
      64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507,
      64'h9159015A3070DD17, 64'h152FECD8F70E5939,
      64'h67332667FFC00B31, 64'h8EB44A8768581511,
      64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
   };

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = SHA384_IV[i];
      msg_fill = 0;
      msg_bits = '0;
   endfunction

   function automatic void compress_block();
      logic [63:0] w [0:79];
      logic [63:0] v [0:7];
      logic [63:0] t1, t2;
      for (int t = 0; t < 16; t++) w[t] = msg_block[t];
      for (int t = 16; t < 80; t++)
         w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
              + (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 80; t++) begin
         t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
         t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endfunction

   function automatic void load_word(input logic [63:0] w);
      msg_block[msg_fill] = w;
      msg_fill = (msg_fill + 1) % 16;
      if (msg_fill == 0) compress_block();
   endfunction

   function automatic void absorb_word(input logic [63:0] data, input logic [3:0] nbytes_in,
                                       input logic fin);
      int              nbytes;
      logic [63:0]     keep;
      digest_item_type d;
      if (!fin) begin
         msg_bits += 128'd64;
         load_word(data);
         return;
      end
      nbytes = (nbytes_in > 8) ? 8 : nbytes_in;
      msg_bits += 128'(nbytes * 8);
      if (nbytes == 8) begin
         load_word(data);
         load_word(64'h80 << 56);
      end else begin
         keep = (nbytes == 0) ? 64'd0 : (~64'd0 << (64 - 8 * nbytes));
         load_word((data & keep) | (64'h80 << (56 - 8 * nbytes)));
      end
      if (msg_fill > 14) while (msg_fill != 0) load_word(64'd0);
      while (msg_fill < 14) load_word(64'd0);
      load_word(msg_bits[127:64]);
      load_word(msg_bits[63:0]);
      for (int i = 0; i < sha384_pkg::DIGEST_WORDS; i++) begin
         d.word  = hash_state[i];
         d.index = 3'(i);
         d.last  = (i == sha384_pkg::DIGEST_WORDS - 1);
         digest_queue.push_back(d);
      end
      restart_message();
   endfunction

   task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes, input logic fin);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.data_word   <= data;
      req.valid_bytes <= nbytes;
      req.final_word  <= fin;
      do @(posedge clock); while (!req.ready);
      absorb_word(data, nbytes, fin);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic send_message(input int nwords, input logic [3:0] nbytes);
      for (int i = 0; i < nwords; i++) send_word(rand_word(), 4'($urandom_range(15)), 1'b0);
      send_word(rand_word(), nbytes, 1'b1);
   endtask

   task automatic test_directed();
      send_word(64'd0, 4'd0, 1'b1);
      send_word(~64'd0, 4'd8, 1'b1);
      send_word(64'h6162630000000000, 4'd3, 1'b1);
      send_word(~64'd0, 4'd15, 1'b1);
      send_word(~64'd0, 4'd9, 1'b1);
      send_word(64'hA5A5A5A5A5A5A5A5, 4'd7, 1'b1);
      send_word(64'h5A5A5A5A5A5A5A5A, 4'd1, 1'b1);
      send_message(13, 4'd8);
      send_message(14, 4'd0);
      drain();
   endtask

   task automatic test_random(input int nitems);
      int sent;
      int len;
      sent = 0;
      while (sent < nitems) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 17);
         send_message(len, 4'($urandom_range(15)));
         sent += len + 1;
      end
      drain();
   endtask

   task automatic test_backpressure();
      hold_off_req = 1'b1;
      send_message(40, 4'd4);
      send_message(3, 4'd8);
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready       <= 1'b0;
         hold_off_seen   <= 1'b0;
         hold_off_cycles <= 0;
      end else if (hold_off_req && !hold_off_seen) begin
         hold_off_seen   <= 1'b1;
         hold_off_cycles <= HOLD_OFF_LEN - 1;
         rsp.ready       <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp.ready       <= 1'b0;
      end else begin
         rsp.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      digest_item_type exp_d;
      if (!reset && rsp.valid && rsp.ready) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: expected none actual %h", $time, rsp.digest_word);
            errors++;
         end else begin
            exp_d = digest_queue.pop_front();
            if (rsp.digest_word !== exp_d.word || rsp.digest_index !== exp_d.index
                || rsp.digest_last !== exp_d.last) begin
               $display("%0t: expected %h/%0d/%0d actual %h/%0d/%0d", $time, exp_d.word,
                        exp_d.index, exp_d.last, rsp.digest_word, rsp.digest_index,
                        rsp.digest_last);
               errors++;
            end
         end
      end
   end

   initial begin
      req.valid       = 1'b0;
      req.data_word   = '0;
      req.valid_bytes = '0;
      req.final_word  = 1'b0;
      hold_off_req    = 1'b0;
      restart_message();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 27;
      recv_idle_pct = 76;
      test_random(90);
      send_idle_pct = 76;
      recv_idle_pct = 27;
      test_random(80);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(90);
      test_backpressure();
      if (errors == 0 && digest_queue.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
